// ===== rtl/dds_pkg.sv =====
// ----------------------------------------------------------------------------
// dds_pkg: shared types and constants of the DDS waveform generator
// Register indexes, wave shape codes, the quarter-wave sine table and the
// fixed widths of the sample path.
// ----------------------------------------------------------------------------
package dds_pkg;

  localparam int BURST_W     = 7;
  localparam int PHASE_W     = 32;
  localparam int DAC_W       = 12;
  localparam int NORM_W      = 16;
  localparam int PROD_W      = DAC_W + 1 + NORM_W;
  localparam int SCALED_W    = DAC_W + 1;
  localparam int SUM_W       = DAC_W + 2;
  localparam int Q15_SHIFT   = 15;
  localparam int SINE_IDX_W  = 7;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int STATE_DEPTH = 2;

  localparam logic [BURST_W-1:0] MAX_BURST = 7'd64;

  localparam logic [1:0] CFG_WAVE_SHAPE = 2'd0;
  localparam logic [1:0] CFG_PHASE_STEP = 2'd1;
  localparam logic [1:0] CFG_AMPLITUDE  = 2'd2;
  localparam logic [1:0] CFG_DC_OFFSET  = 2'd3;

  localparam logic [1:0] SHAPE_SINE     = 2'd0;
  localparam logic [1:0] SHAPE_TRIANGLE = 2'd1;
  localparam logic [1:0] SHAPE_SQUARE   = 2'd2;
  localparam logic [1:0] SHAPE_NOISE    = 2'd3;

  // State memory entries
  localparam logic STATE_PHASE = 1'b0;
  localparam logic STATE_NOISE = 1'b1;

  localparam logic [PHASE_W-1:0] NOISE_SEED = 32'h4075_a17e;

  localparam logic [NORM_W-1:0] NORM_MIN      = 16'h8000;
  localparam logic [NORM_W-1:0] NORM_MAX      = 16'h7FFF;
  localparam logic [NORM_W-1:0] TRI_RISE_BASE = 16'h8000;
  localparam logic [NORM_W-1:0] TRI_FALL_BASE = 16'h7FFF;
  localparam logic [PROD_W-1:0] TRUNC_BIAS    = 29'd32767;
  localparam logic [DAC_W-1:0]  DAC_MAX       = 12'd4095;
  localparam logic [SINE_IDX_W-1:0] SINE_QUARTER = 7'd64;

  localparam logic [14:0] QUARTER_SINE [0:64] = '{
    15'd0,     15'd804,   15'd1608,  15'd2410,  15'd3212,  15'd4011,  15'd4808,
    15'd5602,  15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512,  15'd10278,
    15'd11039, 15'd11793, 15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446,
    15'd16151, 15'd16846, 15'd17530, 15'd18204, 15'd18868, 15'd19519, 15'd20159,
    15'd20787, 15'd21403, 15'd22005, 15'd22594, 15'd23170, 15'd23731, 15'd24279,
    15'd24811, 15'd25329, 15'd25832, 15'd26319, 15'd26790, 15'd27245, 15'd27683,
    15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956, 15'd30273,
    15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971,
    15'd32137, 15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728,
    15'd32757, 15'd32767
  };

  typedef struct packed {
    logic [DAC_W-1:0] dac_code;
    logic             last;
  } sample_t;

endpackage

// ===== rtl/dds_ram.sv =====
// ----------------------------------------------------------------------------
// dds_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; a read of the entry being
// written returns the old contents.
// ----------------------------------------------------------------------------
module dds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/dds_waveform_dac12_top.sv =====
// ----------------------------------------------------------------------------
// dds_waveform_dac12_top: burst waveform generator for a 12-bit DAC
// Each request transfer asks for 0 to 64 samples of sine, triangle, square or
// noise; samples leave one per transfer with tlast on the final one.
// ----------------------------------------------------------------------------
// Sustained rate is one sample per clock while the output queue has room (a
// zero-length request produces nothing), and the next request is taken in the
// cycle its predecessor issues its final sample. The phase accumulator and
// noise register live in a two-entry state RAM that is read, updated and
// written back once per sample, with the previous write forwarded; this loop
// sets the rate. The first sample of a burst passes through the state RAM
// read, stages 1 to 4 and the output queue before it is offered on the sample
// stream. An eight-entry output queue absorbs back-pressure; no clearing pass
// is needed after reset.
module dds_waveform_dac12_top
  import dds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_data,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [6:0] burst_length
  // sample stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [11:0] dac_code
  output logic        m_axis_tlast
);

  logic [1:0]         wave_shape;
  logic [PHASE_W-1:0] phase_step;
  logic [DAC_W-1:0]   amplitude;
  logic [DAC_W-1:0]   dc_offset;

  logic [BURST_W-1:0] remaining;
  logic [BURST_W-1:0] remaining_next;
  logic [BURST_W-1:0] len_sat;
  logic               credit;
  logic               issue;
  logic               req_accept;
  logic [FIFO_AW:0]   inflight;

  logic               rd_addr;
  logic [PHASE_W-1:0] rd_data;
  logic [STATE_DEPTH-1:0] state_valid;

  logic               s1_v;
  logic               s1_last;
  logic               s1_addr;
  logic               s1_rvalid;
  logic [PHASE_W-1:0] cur;
  logic [PHASE_W-1:0] seeded;
  logic [PHASE_W-1:0] xs1;
  logic [PHASE_W-1:0] xs2;
  logic [PHASE_W-1:0] xs3;
  logic [PHASE_W-1:0] state_next;
  logic [NORM_W-1:0]  norm;
  logic [SINE_IDX_W-1:0] sine_idx;
  logic [14:0]        sine_mag;
  logic [15:0]        tri_p;

  logic               wr_v;
  logic               wr_addr;
  logic [PHASE_W-1:0] wr_data;

  logic               s2_v;
  logic               s2_last;
  logic [NORM_W-1:0]  s2_norm;

  logic               s3_v;
  logic               s3_last;
  logic signed [PROD_W-1:0] s3_prod;

  logic               s4_v;
  logic               s4_last;
  logic [SCALED_W-1:0] s4_scaled;

  logic [PROD_W-1:0]  biased;
  logic signed [SUM_W-1:0] sum;
  logic [DAC_W-1:0]   clamped;

  sample_t            fifo_mem [0:FIFO_DEPTH-1];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   fifo_count;
  logic               push;
  logic               pop;
  sample_t            head;

  // Configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_shape <= SHAPE_SINE;
      phase_step <= '0;
      amplitude  <= '0;
      dc_offset  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        CFG_WAVE_SHAPE: wave_shape <= cfg_data[1:0];
        CFG_PHASE_STEP: phase_step <= cfg_data;
        CFG_AMPLITUDE:  amplitude  <= cfg_data[DAC_W-1:0];
        CFG_DC_OFFSET:  dc_offset  <= cfg_data[DAC_W-1:0];
      endcase
    end
  end

  // Burst sequencing and issue
  assign inflight = fifo_count + {{FIFO_AW{1'b0}}, s1_v} + {{FIFO_AW{1'b0}}, s2_v}
                  + {{FIFO_AW{1'b0}}, s3_v} + {{FIFO_AW{1'b0}}, s4_v};
  assign credit   = inflight < (FIFO_AW+1)'(FIFO_DEPTH);
  assign issue    = (remaining != '0) && credit;
  assign s_axis_tready = (remaining == '0) || ((remaining == 7'd1) && credit);
  assign req_accept = s_axis_tvalid && s_axis_tready;
  assign len_sat  = (s_axis_tdata[BURST_W-1:0] > MAX_BURST) ? MAX_BURST
                                                            : s_axis_tdata[BURST_W-1:0];

  always_comb begin
    remaining_next = remaining;
    if (req_accept) begin
      remaining_next = len_sat;
    end else if (issue) begin
      remaining_next = remaining - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else begin
      remaining <= remaining_next;
    end
  end

  // State RAM: phase accumulator and noise register
  assign rd_addr = (wave_shape == SHAPE_NOISE) ? STATE_NOISE : STATE_PHASE;

  dds_ram #(
    .WIDTH (PHASE_W),
    .DEPTH (STATE_DEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (s1_v),
    .waddr (s1_addr),
    .wdata (state_next),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v        <= 1'b0;
      state_valid <= '0;
      wr_v        <= 1'b0;
    end else begin
      s1_v <= issue;
      wr_v <= s1_v;
      if (s1_v) begin
        state_valid[s1_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_last   <= (remaining == 7'd1);
      s1_addr   <= rd_addr;
      s1_rvalid <= state_valid[rd_addr];
    end
    if (s1_v) begin
      wr_addr <= s1_addr;
      wr_data <= state_next;
    end
  end

  // Stage 1: forward, update state, form the Q15 wave value
  always_comb begin
    if (wr_v && (wr_addr == s1_addr)) begin
      cur = wr_data;
    end else if (s1_rvalid) begin
      cur = rd_data;
    end else begin
      cur = '0;
    end

    seeded = (cur == '0) ? NOISE_SEED : cur;
    xs1    = seeded ^ (seeded << 13);
    xs2    = xs1 ^ (xs1 >> 17);
    xs3    = xs2 ^ (xs2 << 5);

    sine_idx = cur[30] ? (SINE_QUARTER - {1'b0, cur[29:24]}) : {1'b0, cur[29:24]};
    sine_mag = QUARTER_SINE[sine_idx];
    tri_p    = {cur[30:16], 1'b0};

    unique case (wave_shape)
      SHAPE_SINE: begin
        norm       = cur[31] ? (NORM_W'(0) - {1'b0, sine_mag}) : {1'b0, sine_mag};
        state_next = cur + phase_step;
      end
      SHAPE_TRIANGLE: begin
        norm       = cur[31] ? (TRI_FALL_BASE - tri_p) : (TRI_RISE_BASE ^ tri_p);
        state_next = cur + phase_step;
      end
      SHAPE_SQUARE: begin
        norm       = cur[31] ? NORM_MIN : NORM_MAX;
        state_next = cur + phase_step;
      end
      SHAPE_NOISE: begin
        norm       = {~xs3[31], xs3[30:16]};
        state_next = xs3;
      end
    endcase
  end

  // Stages 2 to 4: scale, truncate toward zero, offset and clamp
  assign biased = s3_prod[PROD_W-1] ? (s3_prod + TRUNC_BIAS) : s3_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    s2_last   <= s1_last;
    s2_norm   <= norm;
    s3_last   <= s2_last;
    s3_prod   <= $signed({1'b0, amplitude}) * $signed(s2_norm);
    s4_last   <= s3_last;
    s4_scaled <= biased[Q15_SHIFT +: SCALED_W];
  end

  always_comb begin
    sum = $signed({2'b00, dc_offset}) + $signed({s4_scaled[SCALED_W-1], s4_scaled});
    if (sum[SUM_W-1]) begin
      clamped = '0;
    end else if (sum > $signed({2'b00, DAC_MAX})) begin
      clamped = DAC_MAX;
    end else begin
      clamped = sum[DAC_W-1:0];
    end
  end

  // Output queue
  assign push = s4_v;
  assign pop  = m_axis_tvalid && m_axis_tready;
  assign head = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= '{dac_code: clamped, last: s4_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fifo_count <= fifo_count + {{FIFO_AW{1'b0}}, push} - {{FIFO_AW{1'b0}}, pop};
    end
  end

  assign m_axis_tvalid = (fifo_count != '0);
  assign m_axis_tdata  = {{(16-DAC_W){1'b0}}, head.dac_code};
  assign m_axis_tlast  = head.last;

endmodule
